### rtl/core/wpp_pkg.sv
// Package with shared types, constants and the quantizer for the peak pyramid.
`timescale 1ns / 1ps
package wpp_pkg;

   localparam int MAX_LEVELS  = 16;
   localparam int SAMPLE_W    = 24;
   localparam int PEAK_W      = 16;
   localparam int COUNT_W     = 31;
   localparam int TOTAL_W     = 40;
   localparam int FPB_W       = 16;
   localparam int LEVEL_W     = 5;
   localparam logic [FPB_W-1:0] FPB_RESET = 16'd128;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   typedef struct packed {
      logic [COUNT_W-1:0]       count;
      logic signed [PEAK_W-1:0] low;
      logic signed [PEAK_W-1:0] high;
   } entry_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]       level;
      logic [COUNT_W-1:0]       bucket_index;
      logic signed [PEAK_W-1:0] low_peak;
      logic signed [PEAK_W-1:0] high_peak;
      logic                     empty_stream;
      logic [TOTAL_W-1:0]       total_frames;
   } result_type;

   function automatic logic signed [PEAK_W-1:0] quantise(logic signed [SAMPLE_W-1:0] s);
      logic [22:0] mag;
      logic [37:0] prod;
      logic [14:0] q;
      logic signed [PEAK_W-1:0] r;
      mag  = s[23] ? 23'(-s) : s[22:0];
      prod = 38'(mag) * 38'(15'd32767) + 38'(24'd2097152);
      q    = prod[36:22];
      if (s >= 24'sd4194304) begin
         r = 16'sd32767;
      end else if (s <= -24'sd4194304) begin
         r = -16'sd32767;
      end else if (s[23]) begin
         r = -$signed({1'b0, q});
      end else begin
         r = $signed({1'b0, q});
      end
      return r;
   endfunction

endpackage

### rtl/core/wpp_ram.sv
// Per-level memory holding the bucket count and the waiting lone bucket.
`timescale 1ns / 1ps
module wpp_ram #(
   parameter int Depth = wpp_pkg::MAX_LEVELS,
   parameter int AddrW = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrW-1:0]     wr_addr,
   input  wpp_pkg::entry_type   wr_data,
   input  logic [AddrW-1:0]     rd_addr,
   output wpp_pkg::entry_type   rd_data
);
   import wpp_pkg::*;

   entry_type mem [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/wpp_out.sv
// Result staging register and output register that marks the last result.
`timescale 1ns / 1ps
module wpp_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wpp_pkg::result_type  push_data,
   input  logic                 fin,
   output logic                 can_move,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wpp_pkg::result_type  rsp_data,
   output logic                 rsp_last
);
   import wpp_pkg::*;

   result_type hold_ff, hold_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       last_ff, last_in;
   logic       move;

   assign can_move = !hold_valid_ff || !out_valid_ff || rsp_ready;
   assign move     = hold_valid_ff && (push || fin);

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in        = out_ff;
      last_in       = last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      if (move) begin
         out_in       = hold_ff;
         last_in      = fin;
         out_valid_in = 1'b1;
      end
      if (push) begin
         hold_in       = push_data;
         hold_valid_in = 1'b1;
      end else if (fin) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign rsp_last  = last_ff;
endmodule

### rtl/core/waveform_peak_pyramid.sv
// Waveform min/max peak pyramid: bucket front end, level memory and cascade sequencer.
// A sample that closes no bucket leaves the sequencer idle; the next sample is taken the cycle after.
// A closing bucket is quantised first; then each pyramid level it visits is read and emits a result.
// A flush walks the levels through the same memory port, reading and checking each level visited.
// Results leave through a staging register and an output register, so a stalled
// consumer holds the sequencer. Synchronous reset clears all stream state at once.
`timescale 1ns / 1ps
module waveform_peak_pyramid #(
   parameter int MaxLevels = wpp_pkg::MAX_LEVELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [wpp_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wpp_pkg::LEVEL_W-1:0]         rsp_level,
   output logic [wpp_pkg::COUNT_W-1:0]         rsp_bucket_index,
   output logic signed [wpp_pkg::PEAK_W-1:0]   rsp_low_peak,
   output logic signed [wpp_pkg::PEAK_W-1:0]   rsp_high_peak,
   output logic                                rsp_empty_stream,
   output logic [wpp_pkg::TOTAL_W-1:0]         rsp_total_frames,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [wpp_pkg::FPB_W-1:0]           csr_write_data
);
   import wpp_pkg::*;

   localparam int LvlW = $clog2(MaxLevels);
   localparam logic [LvlW-1:0] TopLvl = LvlW'(MaxLevels - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_QUANT, S_CREAD, S_CEMIT, S_FREAD, S_FCHECK, S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [FPB_W-1:0]          fpb_ff;
   logic signed [SAMPLE_W-1:0] bmin_ff, bmin_in, bmax_ff, bmax_in;
   logic [FPB_W-1:0]          fib_ff, fib_in;
   logic                      afs_ff, afs_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic [MaxLevels-1:0]      pv_ff, pv_in, cv_ff, cv_in;
   logic [LvlW-1:0]           lvl_ff, lvl_in, fk_ff, fk_in;
   logic                      flush_ff, flush_in;
   logic signed [PEAK_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;

   logic                      wr_en;
   logic [LvlW-1:0]           rd_addr;
   entry_type                 wr_data, rd_data;
   logic [COUNT_W-1:0]        count;
   logic [COUNT_W-1:0]        count_next;
   logic                      push, fin, can_move;
   result_type                push_data, rsp_data;
   logic [FPB_W:0]            fib_inc;
   logic [FPB_W-1:0]          fpb_eff;
   logic                      first;
   logic signed [PEAK_W-1:0]  fold_lo, fold_hi;

   wpp_ram #(.Depth(MaxLevels), .AddrW(LvlW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lvl_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wpp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .fin       (fin),
      .can_move  (can_move),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign fpb_eff   = (fpb_ff == '0) ? FPB_W'(1) : fpb_ff;
   assign fib_inc   = {1'b0, fib_ff} + 1'b1;
   assign first     = (fib_ff == '0) && afs_ff;
   assign rd_addr   = (state_ff == S_FREAD) ? fk_ff : lvl_ff;

   always_comb begin
      if (state_ff == S_FCHECK) begin
         count = cv_ff[fk_ff] ? rd_data.count : '0;
      end else begin
         count = cv_ff[lvl_ff] ? rd_data.count : '0;
      end
   end

   assign count_next = (count == '1) ? count : count + 1'b1;
   assign fold_lo    = (rd_data.low < lo_ff) ? rd_data.low : lo_ff;
   assign fold_hi    = (rd_data.high > hi_ff) ? rd_data.high : hi_ff;

   always_comb begin
      state_in  = state_ff;
      bmin_in   = bmin_ff;
      bmax_in   = bmax_ff;
      fib_in    = fib_ff;
      afs_in    = afs_ff;
      total_in  = total_ff;
      pv_in     = pv_ff;
      cv_in     = cv_ff;
      lvl_in    = lvl_ff;
      fk_in     = fk_ff;
      flush_in  = flush_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      wr_en     = 1'b0;
      wr_data   = rd_data;
      push      = 1'b0;
      fin       = 1'b0;
      push_data = '{level: LEVEL_W'(lvl_ff), bucket_index: count, low_peak: lo_ff,
                    high_peak: hi_ff, empty_stream: 1'b0, total_frames: total_ff};
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_SAMPLE) begin
                  if (first || req_sample < bmin_ff) bmin_in = req_sample;
                  if (first || req_sample > bmax_ff) bmax_in = req_sample;
                  afs_in = req_frame_end;
                  if (req_frame_end) begin
                     if (total_ff != '1) total_in = total_ff + 1'b1;
                     if (fib_inc >= {1'b0, fpb_eff}) begin
                        fib_in   = '0;
                        flush_in = 1'b0;
                        state_in = S_QUANT;
                     end else begin
                        fib_in = fib_inc[FPB_W-1:0];
                     end
                  end
               end else begin
                  flush_in = 1'b1;
                  fk_in    = '0;
                  if (total_ff == '0) begin
                     push      = 1'b1;
                     push_data = '{level: '0, bucket_index: '0, low_peak: '0,
                                   high_peak: '0, empty_stream: 1'b1, total_frames: '0};
                     state_in  = S_FINISH;
                  end else if (fib_ff != '0) begin
                     fib_in   = '0;
                     state_in = S_QUANT;
                  end else begin
                     state_in = S_FREAD;
                  end
               end
            end
         end
         S_QUANT: begin
            lo_in    = quantise(bmin_ff);
            hi_in    = quantise(bmax_ff);
            lvl_in   = '0;
            state_in = S_CREAD;
         end
         S_CREAD: begin
            state_in = S_CEMIT;
         end
         S_CEMIT: begin
            if (can_move) begin
               push          = 1'b1;
               wr_en         = 1'b1;
               cv_in[lvl_ff] = 1'b1;
               wr_data.count = count_next;
               if (lvl_ff == TopLvl) begin
                  state_in = flush_ff ? S_FREAD : S_FINISH;
               end else if (pv_ff[lvl_ff]) begin
                  pv_in[lvl_ff] = 1'b0;
                  lo_in         = fold_lo;
                  hi_in         = fold_hi;
                  lvl_in        = lvl_ff + 1'b1;
                  state_in      = S_CREAD;
               end else begin
                  wr_data.low   = lo_ff;
                  wr_data.high  = hi_ff;
                  pv_in[lvl_ff] = 1'b1;
                  state_in      = flush_ff ? S_FREAD : S_FINISH;
               end
            end
         end
         S_FREAD: begin
            state_in = S_FCHECK;
         end
         S_FCHECK: begin
            if (fk_ff == TopLvl || count <= COUNT_W'(1)) begin
               state_in = S_FINISH;
            end else if (pv_ff[fk_ff]) begin
               pv_in[fk_ff] = 1'b0;
               lo_in        = rd_data.low;
               hi_in        = rd_data.high;
               lvl_in       = fk_ff + 1'b1;
               fk_in        = fk_ff + 1'b1;
               state_in     = S_CREAD;
            end else begin
               fk_in    = fk_ff + 1'b1;
               state_in = S_FREAD;
            end
         end
         S_FINISH: begin
            if (can_move) begin
               fin      = 1'b1;
               state_in = S_IDLE;
               if (flush_ff) begin
                  bmin_in  = '0;
                  bmax_in  = '0;
                  fib_in   = '0;
                  afs_in   = 1'b1;
                  total_in = '0;
                  pv_in    = '0;
                  cv_in    = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fpb_ff   <= FPB_RESET;
         bmin_ff  <= '0;
         bmax_ff  <= '0;
         fib_ff   <= '0;
         afs_ff   <= 1'b1;
         total_ff <= '0;
         pv_ff    <= '0;
         cv_ff    <= '0;
         flush_ff <= 1'b0;
         lvl_ff   <= '0;
         fk_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) fpb_ff <= csr_write_data;
         bmin_ff  <= bmin_in;
         bmax_ff  <= bmax_in;
         fib_ff   <= fib_in;
         afs_ff   <= afs_in;
         total_ff <= total_in;
         pv_ff    <= pv_in;
         cv_ff    <= cv_in;
         flush_ff <= flush_in;
         lvl_ff   <= lvl_in;
         fk_ff    <= fk_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   assign rsp_level        = rsp_data.level;
   assign rsp_bucket_index = rsp_data.bucket_index;
   assign rsp_low_peak     = rsp_data.low_peak;
   assign rsp_high_peak    = rsp_data.high_peak;
   assign rsp_empty_stream = rsp_data.empty_stream;
   assign rsp_total_frames = rsp_data.total_frames;
endmodule

### rtl/core/wpp_checker.sv
// Port-level checker for the peak pyramid and its bind to the top level.
`timescale 1ns / 1ps
module wpp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_operation,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [wpp_pkg::LEVEL_W-1:0]         rsp_level,
   input logic signed [wpp_pkg::PEAK_W-1:0]   rsp_low_peak,
   input logic signed [wpp_pkg::PEAK_W-1:0]   rsp_high_peak,
   input logic                                rsp_empty_stream,
   input logic [wpp_pkg::TOTAL_W-1:0]         rsp_total_frames,
   input logic                                rsp_last
);
   import wpp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result transaction dropped while stalled.");

   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_FLUSH |=> !req_ready)
      else $error("Input accepted in the cycle after a flush.");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_stream |-> rsp_last && rsp_level == '0
                                         && rsp_total_frames == '0)
      else $error("Malformed empty-stream result.");

   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_low_peak != -16'sd32768 && rsp_high_peak != -16'sd32768)
      else $error("Peak outside the symmetric range.");
endmodule

bind waveform_peak_pyramid wpp_checker u_wpp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_level        (rsp_level),
   .rsp_low_peak     (rsp_low_peak),
   .rsp_high_peak    (rsp_high_peak),
   .rsp_empty_stream (rsp_empty_stream),
   .rsp_total_frames (rsp_total_frames),
   .rsp_last         (rsp_last)
);
